[hw/rtl/sqt_pkg.sv]
// sqt_pkg: types, codes and byte helpers for the search query tokenizer
// no dependencies; imported by search_query_tokenizer_unit
`default_nettype none

package sqt_pkg;

  // default width of the byte position counters
  localparam int unsigned POSITION_BITS_DEF = 16;

  // result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;
  // most results one input beat can cause
  localparam int unsigned MAX_PUSH   = 3;

  // register reset values
  localparam logic [7:0] MAX_TERM_RST    = 8'd64;
  localparam logic [9:0] MAX_PHRASE_RST  = 10'd256;
  localparam logic [7:0] MAX_WORDS_RST   = 8'd16;
  localparam logic [7:0] MAX_UNITS_RST   = 8'd32;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_TERM   = 2'd0;
  localparam logic [1:0] REG_MAX_PHRASE = 2'd1;
  localparam logic [1:0] REG_MAX_WORDS  = 2'd2;
  localparam logic [1:0] REG_MAX_UNITS  = 2'd3;

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // result event codes
  localparam logic [1:0] EV_BYTE     = 2'd0;
  localparam logic [1:0] EV_UNIT_END = 2'd1;
  localparam logic [1:0] EV_STATUS   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_UNMATCHED     = 3'd1;
  localparam logic [2:0] ST_EMPTY_PREFIX  = 3'd2;
  localparam logic [2:0] ST_TERM_LONG     = 3'd3;
  localparam logic [2:0] ST_EMPTY_PHRASE  = 3'd4;
  localparam logic [2:0] ST_PHRASE_LONG   = 3'd5;
  localparam logic [2:0] ST_TOO_MANY      = 3'd6;

  // characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // saturation points of the unit counters
  localparam logic [10:0] ULEN_TOP = 11'd1024;
  localparam logic [8:0]  WCNT_TOP = 9'd256;
  localparam logic [7:0]  WLEN_TOP = 8'd255;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_TERM    = 2'd1,
    MODE_PHRASE  = 2'd2,
    MODE_AFTER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  byte_val;
    logic        is_phrase;
    logic        new_word;
    logic        prefix_mark;
    logic [2:0]  status;
    logic [15:0] offset;
  } res_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    return ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? (b + CASE_OFS) : b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/search_query_tokenizer_unit.sv]
// search_query_tokenizer_unit: splits a query byte stream into terms and phrases
// depends on sqt_pkg (types, codes, byte helpers)
`default_nettype none

// One query byte or end beat is taken per cycle on the in_ channel while in_stall
// is low. Each beat updates the scan state and writes up to three results (held
// term byte, unit end, final status) into an 8-entry result queue; the out_
// channel drains one result per cycle from the queue head while out_stall is
// low. in_stall rises while the queue has fewer than three free entries. A
// plain byte stream runs at one beat per cycle while the output does not stall,
// and the sustained rate is set by the single-result-per-cycle output port.
// Each term byte is held back until another beat arrives, so that a trailing
// star can be dropped. Errors never stop the output; the status at the end of
// the query reports the first failing unit and its start offset, with an
// unmatched quote taking priority. Limits are set through the cfg_ write port
// (0 term length, 1 phrase length, 2 phrase words, 3 units); the user must write
// them only while the block is idle, which the block itself does not enforce.
module search_query_tokenizer_unit #(
  parameter int unsigned POSITION_BITS = sqt_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_byte,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic [7:0]       out_byte,
  output logic             out_unit_is_phrase,
  output logic             out_new_word,
  output logic             out_prefix_mark,
  output logic [2:0]       out_status,
  output logic [15:0]      out_error_offset
);
  import sqt_pkg::*;

  // limit registers
  logic [7:0] max_term_r;
  logic [9:0] max_phrase_r;
  logic [7:0] max_words_r;
  logic [7:0] max_units_r;

  // scan state
  mode_t                    mode_r, mode_nxt;
  logic [7:0]               held_byte_r, held_byte_nxt;
  logic                     held_valid_r, held_valid_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] unit_start_r, unit_start_nxt;
  logic [10:0]              ulen_r, ulen_nxt;
  logic [8:0]               wcnt_r, wcnt_nxt;
  logic [7:0]               wlen_r, wlen_nxt;
  logic                     in_word_r, in_word_nxt;
  logic [7:0]               units_r, units_nxt;
  logic [2:0]               ferr_r, ferr_nxt;
  logic [POSITION_BITS-1:0] ferr_off_r, ferr_off_nxt;

  // result queue
  res_t                  fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  // per-beat decode
  logic        in_acc, pop;
  logic        b_ws, b_quote, b_star;
  logic        term_fin, held_star, t_emit, do_end, end_pre, ph_byte, begin_u;
  logic [10:0] term_len;
  logic [2:0]  code, st_fin;
  logic [7:0]  wl_base;
  logic [POSITION_BITS-1:0] off_fin;
  logic [31:0] off_wide;
  res_t        push_d [MAX_PUSH];
  logic [1:0]  n_push;

  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = cnt_r > FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH);

  assign b_ws    = is_ws(in_byte);
  assign b_quote = (in_byte == CH_QUOTE);
  assign b_star  = (in_byte == CH_STAR);

  // a term closes on whitespace, a quote or the end beat
  assign term_fin  = (mode_r == MODE_TERM) && ((in_cmd == CMD_END) || b_ws || b_quote);
  assign held_star = held_valid_r && (held_byte_r == CH_STAR);
  // held byte goes out unless it is the trailing star of a closing term
  assign t_emit    = (mode_r == MODE_TERM) && held_valid_r && !(term_fin && held_star);
  assign do_end    = term_fin || (mode_r == MODE_AFTER);
  assign end_pre   = term_fin ? held_star : ((in_cmd == CMD_BYTE) && b_star);
  assign ph_byte   = (mode_r == MODE_PHRASE) && (in_cmd == CMD_BYTE) && !b_quote;
  assign begin_u   = (in_cmd == CMD_BYTE) && !b_ws &&
                     (term_fin || (mode_r == MODE_BETWEEN) ||
                      ((mode_r == MODE_AFTER) && !b_star));
  assign term_len  = ulen_r - 11'((end_pre && (ulen_r != 11'd0)) ? 1 : 0);
  assign wl_base   = in_word_r ? wlen_r : 8'd0;

  always_comb begin
    mode_nxt       = mode_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    pos_nxt        = pos_r;
    unit_start_nxt = unit_start_r;
    ulen_nxt       = ulen_r;
    wcnt_nxt       = wcnt_r;
    wlen_nxt       = wlen_r;
    in_word_nxt    = in_word_r;
    units_nxt      = units_r;
    ferr_nxt       = ferr_r;
    ferr_off_nxt   = ferr_off_r;
    code           = ST_OK;
    st_fin         = ST_OK;
    off_fin        = '0;
    off_wide       = '0;
    n_push         = 2'd0;
    for (int i = 0; i < MAX_PUSH; i++) begin
      push_d[i] = '0;
    end

    if (in_acc) begin
      // held term byte
      if (t_emit) begin
        if (wlen_r < max_term_r) begin
          push_d[n_push].event_res = EV_BYTE;
          push_d[n_push].byte_val  = fold_byte(held_byte_r);
          n_push = n_push + 2'd1;
        end
        if (wlen_r < WLEN_TOP) wlen_nxt = wlen_r + 8'd1;
      end

      case (mode_r)
        MODE_TERM: begin
          if (term_fin) begin
            held_valid_nxt = 1'b0;
            mode_nxt       = MODE_BETWEEN;
          end else begin
            held_byte_nxt  = in_byte;
            held_valid_nxt = 1'b1;
            if (ulen_r < ULEN_TOP) ulen_nxt = ulen_r + 11'd1;
          end
        end
        MODE_PHRASE: begin
          if (in_cmd == CMD_BYTE && b_quote) begin
            mode_nxt = MODE_AFTER;
          end
        end
        MODE_AFTER: begin
          mode_nxt = MODE_BETWEEN;
        end
        default: begin
        end
      endcase

      // phrase content byte
      if (ph_byte) begin
        if (ulen_r < ULEN_TOP) ulen_nxt = ulen_r + 11'd1;
        if (b_ws) begin
          in_word_nxt = 1'b0;
        end else begin
          in_word_nxt = 1'b1;
          if (!in_word_r && (wcnt_r < WCNT_TOP)) wcnt_nxt = wcnt_r + 9'd1;
          if (wl_base < max_term_r) begin
            push_d[n_push].event_res = EV_BYTE;
            push_d[n_push].byte_val  = fold_byte(in_byte);
            push_d[n_push].is_phrase = 1'b1;
            push_d[n_push].new_word  = !in_word_r;
            n_push = n_push + 2'd1;
          end
          wlen_nxt = (wl_base < WLEN_TOP) ? (wl_base + 8'd1) : wl_base;
        end
      end

      // unit end and its limit check
      if (do_end) begin
        if (mode_r == MODE_TERM) begin
          if (end_pre && (term_len == 11'd0)) code = ST_EMPTY_PREFIX;
          else if (term_len > {3'd0, max_term_r}) code = ST_TERM_LONG;
        end else begin
          if (ulen_r == 11'd0) code = ST_EMPTY_PHRASE;
          else if ((ulen_r > {1'b0, max_phrase_r}) || (wcnt_r > {1'b0, max_words_r}))
            code = ST_PHRASE_LONG;
        end
        if (ferr_r == ST_OK) begin
          if (code == ST_OK) begin
            if (units_r >= max_units_r) code = ST_TOO_MANY;
            else units_nxt = units_r + 8'd1;
          end
          if (code != ST_OK) begin
            ferr_nxt     = code;
            ferr_off_nxt = unit_start_r;
          end
        end
        push_d[n_push].event_res   = EV_UNIT_END;
        push_d[n_push].is_phrase   = (mode_r == MODE_AFTER);
        push_d[n_push].prefix_mark = end_pre;
        n_push = n_push + 2'd1;
      end

      // start of a new unit
      if (begin_u) begin
        unit_start_nxt = pos_r;
        wlen_nxt       = 8'd0;
        wcnt_nxt       = 9'd0;
        in_word_nxt    = 1'b0;
        if (b_quote) begin
          mode_nxt = MODE_PHRASE;
          ulen_nxt = 11'd0;
        end else begin
          mode_nxt       = MODE_TERM;
          held_byte_nxt  = in_byte;
          held_valid_nxt = 1'b1;
          ulen_nxt       = 11'd1;
        end
      end

      if (in_cmd == CMD_END) begin
        // an open phrase at the end beats any earlier error
        if (mode_r == MODE_PHRASE) begin
          st_fin  = ST_UNMATCHED;
          off_fin = unit_start_r;
        end else begin
          st_fin  = ferr_nxt;
          off_fin = ferr_off_nxt;
        end
        off_wide = 32'(off_fin);
        push_d[n_push].event_res = EV_STATUS;
        push_d[n_push].status    = st_fin;
        if (st_fin != ST_OK) begin
          push_d[n_push].offset = (off_wide > 32'd65535) ? 16'hFFFF : off_wide[15:0];
        end
        n_push = n_push + 2'd1;
        // query state back to reset
        mode_nxt       = MODE_BETWEEN;
        held_byte_nxt  = 8'd0;
        held_valid_nxt = 1'b0;
        pos_nxt        = '0;
        unit_start_nxt = '0;
        ulen_nxt       = 11'd0;
        wcnt_nxt       = 9'd0;
        wlen_nxt       = 8'd0;
        in_word_nxt    = 1'b0;
        units_nxt      = 8'd0;
        ferr_nxt       = ST_OK;
        ferr_off_nxt   = '0;
      end else if (pos_r != '1) begin
        pos_nxt = pos_r + POSITION_BITS'(1);
      end
    end
  end

  // control and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_term_r   <= MAX_TERM_RST;
      max_phrase_r <= MAX_PHRASE_RST;
      max_words_r  <= MAX_WORDS_RST;
      max_units_r  <= MAX_UNITS_RST;
      mode_r       <= MODE_BETWEEN;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      pos_r        <= '0;
      unit_start_r <= '0;
      ulen_r       <= 11'd0;
      wcnt_r       <= 9'd0;
      wlen_r       <= 8'd0;
      in_word_r    <= 1'b0;
      units_r      <= 8'd0;
      ferr_r       <= ST_OK;
      ferr_off_r   <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_TERM:   max_term_r   <= cfg_data[7:0];
          REG_MAX_PHRASE: max_phrase_r <= cfg_data;
          REG_MAX_WORDS:  max_words_r  <= cfg_data[7:0];
          REG_MAX_UNITS:  max_units_r  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      mode_r       <= mode_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      pos_r        <= pos_nxt;
      unit_start_r <= unit_start_nxt;
      ulen_r       <= ulen_nxt;
      wcnt_r       <= wcnt_nxt;
      wlen_r       <= wlen_nxt;
      in_word_r    <= in_word_nxt;
      units_r      <= units_nxt;
      ferr_r       <= ferr_nxt;
      ferr_off_r   <= ferr_off_nxt;
      wr_ptr_r     <= wr_ptr_r + FIFO_PTR_W'(n_push);
      rd_ptr_r     <= rd_ptr_r + FIFO_PTR_W'(pop);
      cnt_r        <= cnt_r + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < n_push) begin
        fifo_mem_r[FIFO_PTR_W'(wr_ptr_r + FIFO_PTR_W'(i))] <= push_d[i];
      end
    end
  end

  // queue head drives the result beat
  assign out_valid          = (cnt_r != '0);
  assign out_event_res      = fifo_mem_r[rd_ptr_r].event_res;
  assign out_byte           = fifo_mem_r[rd_ptr_r].byte_val;
  assign out_unit_is_phrase = fifo_mem_r[rd_ptr_r].is_phrase;
  assign out_new_word       = fifo_mem_r[rd_ptr_r].new_word;
  assign out_prefix_mark    = fifo_mem_r[rd_ptr_r].prefix_mark;
  assign out_status         = fifo_mem_r[rd_ptr_r].status;
  assign out_error_offset   = fifo_mem_r[rd_ptr_r].offset;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // an end beat returns the scan state to its idle values
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_END) |=>
      (mode_r == MODE_BETWEEN && pos_r == '0 && ferr_r == ST_OK && units_r == 8'd0))
    else $error("query state not cleared after end");

  // the first error sticks until the query ends
  a_ferr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ferr_r != ST_OK && !(in_acc && in_cmd == CMD_END)) |=>
      (ferr_r == $past(ferr_r) && ferr_off_r == $past(ferr_off_r)))
    else $error("first error changed mid query");

  // a held byte exists only inside a term
  a_held_term: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (mode_r == MODE_TERM))
    else $error("held byte outside a term");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for search_query_tokenizer_unit
// depends on sqt_pkg and the tokenizer rtl; holds its own scan-state predictor

module tb_top;
  import sqt_pkg::*;

  // watchdog, far above the slowest legal run
  localparam int CYCLE_LIMIT = 50000;
  // quiet cycles allowed for a beat that makes no result
  localparam int SETTLE_CYCLES = 10;

  // whitespace bytes as the tokenizer sees them, plus the underscore filler
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_res;
  logic [7:0]  out_byte;
  logic        out_unit_is_phrase;
  logic        out_new_word;
  logic        out_prefix_mark;
  logic [2:0]  out_status;
  logic [15:0] out_error_offset;

  search_query_tokenizer_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_byte          (out_byte),
    .out_unit_is_phrase(out_unit_is_phrase),
    .out_new_word      (out_new_word),
    .out_prefix_mark   (out_prefix_mark),
    .out_status        (out_status),
    .out_error_offset  (out_error_offset)
  );

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  int idle_pct;      // chance in 100 that the sender skips a cycle
  int stall_pct;     // chance in 100 that the receiver stalls a cycle
  int hold_left;     // forced receiver hold-off, counted down by the receiver
  int fail_count;
  int beats_sent;
  int cycle_count;

  // tokens the block still owes, oldest first
  res_t tok_events_due[$];

  // predictor copy of the limit registers
  logic [7:0] lim_term;
  logic [9:0] lim_phrase;
  logic [7:0] lim_words;
  logic [7:0] lim_units;

  // predictor copy of the scan state
  mode_t       scan_q;
  logic [7:0]  held_q;
  logic        held_ok;
  logic [15:0] pos_q;
  logic [15:0] start_q;
  logic [10:0] ulen_q;
  logic [8:0]  wcnt_q;
  logic [7:0]  wlen_q;
  logic        inword_q;
  logic [7:0]  nunits_q;
  logic [2:0]  err_q;
  logic [15:0] erroff_q;

  // ---------------------------------------------------------------------------
  // tokenizer predictor
  // ---------------------------------------------------------------------------
  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] lower_case(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
  endfunction

  function automatic void push_token(input logic [1:0] ev, input logic [7:0] b,
                                     input logic phr, input logic nw,
                                     input logic pre, input logic [2:0] st,
                                     input logic [15:0] off);
    res_t r;
    r.event_res   = ev;
    r.byte_val    = b;
    r.is_phrase   = phr;
    r.new_word    = nw;
    r.prefix_mark = pre;
    r.status      = st;
    r.offset      = off;
    tok_events_due.insert(tok_events_due.size(), r);
  endfunction

  function automatic void clear_scan();
    scan_q   = MODE_BETWEEN;
    held_q   = 8'd0;
    held_ok  = 1'b0;
    pos_q    = 16'd0;
    start_q  = 16'd0;
    ulen_q   = 11'd0;
    wcnt_q   = 9'd0;
    wlen_q   = 8'd0;
    inword_q = 1'b0;
    nunits_q = 8'd0;
    err_q    = ST_OK;
    erroff_q = 16'd0;
  endfunction

  // limit checks for the closing unit, first failure sticks
  function automatic void close_unit(input bit phrase, input bit prefix);
    logic [2:0]  code;
    logic [10:0] len;
    code = ST_OK;
    if (!phrase) begin
      len = ulen_q - ((prefix && ulen_q != 11'd0) ? 11'd1 : 11'd0);
      if (prefix && len == 11'd0) code = ST_EMPTY_PREFIX;
      else if (len > {3'd0, lim_term}) code = ST_TERM_LONG;
    end else begin
      if (ulen_q == 11'd0) code = ST_EMPTY_PHRASE;
      else if (ulen_q > {1'b0, lim_phrase} || wcnt_q > {1'b0, lim_words})
        code = ST_PHRASE_LONG;
    end
    if (err_q == ST_OK) begin
      if (code == ST_OK) begin
        if (nunits_q >= lim_units) code = ST_TOO_MANY;
        else nunits_q++;
      end
      if (code != ST_OK) begin
        err_q    = code;
        erroff_q = start_q;
      end
    end
    push_token(EV_UNIT_END, 8'd0, phrase, 1'b0, prefix, ST_OK, 16'd0);
  endfunction

  // a term byte goes out only below the length limit
  function automatic void emit_term_byte(input logic [7:0] b);
    if (wlen_q < lim_term) push_token(EV_BYTE, lower_case(b), 1'b0, 1'b0, 1'b0, ST_OK, 16'd0);
    if (wlen_q != WLEN_TOP) wlen_q++;
  endfunction

  // flush the held byte; a held star makes it a prefix term
  function automatic void close_term();
    bit prefix;
    prefix = 1'b0;
    if (held_ok) begin
      if (held_q == CH_STAR) prefix = 1'b1;
      else emit_term_byte(held_q);
    end
    held_ok = 1'b0;
    close_unit(1'b0, prefix);
    scan_q = MODE_BETWEEN;
  endfunction

  function automatic void open_unit(input logic [7:0] b);
    if (blank_char(b)) return;
    start_q  = pos_q;
    wlen_q   = 8'd0;
    wcnt_q   = 9'd0;
    inword_q = 1'b0;
    if (b == CH_QUOTE) begin
      scan_q = MODE_PHRASE;
      ulen_q = 11'd0;
    end else begin
      scan_q  = MODE_TERM;
      held_q  = b;
      held_ok = 1'b1;
      ulen_q  = 11'd1;
    end
  endfunction

  function automatic void phrase_char(input logic [7:0] b);
    if (ulen_q < ULEN_TOP) ulen_q++;
    if (blank_char(b)) begin
      inword_q = 1'b0;
      return;
    end
    if (!inword_q) begin
      inword_q = 1'b1;
      wlen_q   = 8'd0;
      if (wcnt_q < WCNT_TOP) wcnt_q++;
      if (wlen_q < lim_term) push_token(EV_BYTE, lower_case(b), 1'b1, 1'b1, 1'b0, ST_OK, 16'd0);
    end else if (wlen_q < lim_term) begin
      push_token(EV_BYTE, lower_case(b), 1'b1, 1'b0, 1'b0, ST_OK, 16'd0);
    end
    if (wlen_q != WLEN_TOP) wlen_q++;
  endfunction

  // one accepted input beat: advance the scan state, queue the owed tokens
  function automatic void tokenize_beat(input logic c, input logic [7:0] b);
    logic [2:0]  st;
    logic [15:0] off;
    if (c == CMD_END) begin
      if (scan_q == MODE_TERM) close_term();
      else if (scan_q == MODE_AFTER) close_unit(1'b1, 1'b0);
      // an open phrase overrides any earlier unit error
      if (scan_q == MODE_PHRASE) begin
        st  = ST_UNMATCHED;
        off = start_q;
      end else begin
        st  = err_q;
        off = erroff_q;
      end
      push_token(EV_STATUS, 8'd0, 1'b0, 1'b0, 1'b0, st, (st == ST_OK) ? 16'd0 : off);
      clear_scan();
    end else begin
      case (scan_q)
        MODE_TERM: begin
          if (blank_char(b) || b == CH_QUOTE) begin
            close_term();
            open_unit(b);
          end else begin
            if (held_ok) emit_term_byte(held_q);
            held_q  = b;
            held_ok = 1'b1;
            if (ulen_q < ULEN_TOP) ulen_q++;
          end
        end
        MODE_PHRASE: begin
          if (b == CH_QUOTE) scan_q = MODE_AFTER;
          else phrase_char(b);
        end
        MODE_AFTER: begin
          // a star right after the closing quote marks a prefix phrase
          scan_q = MODE_BETWEEN;
          if (b == CH_STAR) begin
            close_unit(1'b1, 1'b1);
          end else begin
            close_unit(1'b1, 1'b0);
            open_unit(b);
          end
        end
        default: open_unit(b);
      endcase
      if (pos_q != 16'hFFFF) pos_q++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog, receiver, result checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // receiver: forced hold-off first, otherwise random stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // every accepted result beat against the oldest owed token
  initial begin
    res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (tok_events_due.size() == 0) begin
          $error("unexpected result beat: event_res %0d", out_event_res);
          fail_count++;
        end else begin
          want = tok_events_due.pop_front();
          if (out_event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, out_event_res);
            fail_count++;
          end
          if (out_byte !== want.byte_val) begin
            $error("out_byte: expected %02h, got %02h", want.byte_val, out_byte);
            fail_count++;
          end
          if (out_unit_is_phrase !== want.is_phrase) begin
            $error("unit_is_phrase: expected %0b, got %0b", want.is_phrase,
                   out_unit_is_phrase);
            fail_count++;
          end
          if (out_new_word !== want.new_word) begin
            $error("new_word: expected %0b, got %0b", want.new_word, out_new_word);
            fail_count++;
          end
          if (out_prefix_mark !== want.prefix_mark) begin
            $error("prefix_mark: expected %0b, got %0b", want.prefix_mark,
                   out_prefix_mark);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_error_offset !== want.offset) begin
            $error("error_offset: expected %0d, got %0d", want.offset, out_error_offset);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // offer one beat, hold it while stalled, predict once it is taken
  task automatic send_beat(input logic c, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd   = c;
    in_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_beat(c, b);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(CMD_BYTE, s[i]);
  endtask

  // end beat; the byte lane is don't-care so it carries noise
  task automatic send_end();
    send_beat(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_query(input string s);
    send_text(s);
    send_end();
  endtask

  // drop valid and wait out every owed token plus the settle time
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tok_events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      REG_MAX_TERM:   lim_term   = val[7:0];
      REG_MAX_PHRASE: lim_phrase = val;
      REG_MAX_WORDS:  lim_words  = val[7:0];
      REG_MAX_UNITS:  lim_units  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // only called with the block idle
  task automatic set_limits(input logic [9:0] t, input logic [9:0] p,
                            input logic [9:0] w, input logic [9:0] u);
    write_limit(REG_MAX_TERM, t);
    write_limit(REG_MAX_PHRASE, p);
    write_limit(REG_MAX_WORDS, w);
    write_limit(REG_MAX_UNITS, u);
  endtask

  // ---------------------------------------------------------------------------
  // random query pieces
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // term bytes: mostly letters, some raw bytes (a star can land mid-term)
  function automatic logic [7:0] pick_term_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CH_UP_A + 8'($urandom_range(0, 25));
      1, 2: c = CH_UP_A + CASE_OFS + 8'($urandom_range(0, 25));
      default: c = 8'($urandom_range(0, 255));
    endcase
    if (blank_char(c) || c == CH_QUOTE) c = CH_UNDER;
    return c;
  endfunction

  // phrase bytes: anything but the quote, blanks split words
  function automatic logic [7:0] pick_phrase_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) c = CH_UP_A + 8'($urandom_range(0, 25)) +
                                        (($urandom_range(0, 1) != 0) ? CASE_OFS : 8'd0);
    else c = 8'($urandom_range(0, 255));
    if (c == CH_QUOTE) c = CH_UNDER;
    return c;
  endfunction

  // small values most of the time so that every limit trips now and then
  function automatic logic [9:0] pick_limit(input int top);
    case ($urandom_range(0, 5))
      0: return 10'd1;
      1: return 10'(top);
      2, 3: return 10'($urandom_range(1, 4));
      default: return 10'($urandom_range(1, top));
    endcase
  endfunction

  // a query of terms, phrases and some noise, closed by an end beat
  task automatic send_random_query();
    int units;
    int kind;
    int words;
    int len;
    units = $urandom_range(0, 3);
    for (int u = 0; u < units; u++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // bare term, zero bytes plus star gives the empty prefix case
        len = $urandom_range(0, 7);
        for (int i = 0; i < len; i++) send_beat(CMD_BYTE, pick_term_char());
        if (len == 0 || $urandom_range(0, 3) == 0) send_beat(CMD_BYTE, CH_STAR);
      end else if (kind < 8) begin
        send_beat(CMD_BYTE, CH_QUOTE);
        words = $urandom_range(0, 4);
        for (int w = 0; w < words; w++) begin
          if (w > 0 || $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) send_beat(CMD_BYTE, pick_blank());
          end
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) send_beat(CMD_BYTE, pick_phrase_char());
        end
        // last phrase sometimes left open
        if (u < units - 1 || $urandom_range(0, 9) != 0) begin
          send_beat(CMD_BYTE, CH_QUOTE);
          if ($urandom_range(0, 2) == 0) send_beat(CMD_BYTE, CH_STAR);
        end
      end else begin
        // raw noise, any byte value
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 2)) send_beat(CMD_BYTE, pick_blank());
      end
    end
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset-default limits: terms, phrases, stars, quotes and byte extremes
  task automatic test_basic_queries();
    logic [7:0] odd_bytes [16] = '{8'h00, 8'hFF, CH_TAB, 8'h41, CH_LF, 8'h5A, CH_VT,
                                   8'h40, CH_FF, 8'h5B, CH_CR, 8'h7F, CH_SPACE,
                                   CH_QUOTE, 8'h80, CH_QUOTE};
    idle_pct  = 21;
    stall_pct = 21;
    send_query("Hello WORLD");
    send_query("  pre* \"Big  Dog\"* x");
    send_query("*");                      // star alone: empty prefix term
    send_query("ab \"\" cd");             // empty phrase
    send_query("\"   \"");                // whitespace-only phrase, zero words
    send_query("* go");                   // output keeps going after an error
    send_query("ok* \"open words");       // unmatched quote wins
    send_query("a\"b c\"d a*b \"x\"\"y\"");
    send_query("\"q\"");                  // end right after a closing quote
    send_query("");                       // empty query
    // byte-value extremes, all blanks, letters at the fold boundaries
    foreach (odd_bytes[i]) send_beat(CMD_BYTE, odd_bytes[i]);
    send_end();
  endtask

  // each limit trips, then low, high and zero register settings
  task automatic test_limits();
    wait_idle();
    set_limits(10'd3, 10'd5, 10'd2, 10'd2);
    send_query("abcd* ab \"abcdef\"");    // long term is truncated on output
    send_query("x* \"a b c\"");           // too many phrase words
    send_query("a b c");                  // third unit over the unit limit
    send_query("\"AbCdEfG\"");            // phrase content too long
    wait_idle();
    set_limits(10'd1, 10'd1, 10'd1, 10'd1);
    send_query("a \"b\" c*");
    wait_idle();
    set_limits(10'd255, 10'd1023, 10'd255, 10'd255);
    send_query("Ab \"Cd Ef\"* gh*");
    wait_idle();
    // zero limits: no term or phrase bytes go out, and every unit fails a check
    set_limits(10'd0, 10'd0, 10'd0, 10'd0);
    send_query("ab \"cd\" \"  \" *");
    wait_idle();
    set_limits(10'(MAX_TERM_RST), MAX_PHRASE_RST, 10'(MAX_WORDS_RST), 10'd0);
    send_query("a");
    wait_idle();
    set_limits(10'(MAX_TERM_RST), MAX_PHRASE_RST, 10'(MAX_WORDS_RST),
               10'(MAX_UNITS_RST));
  endtask

  // long receiver hold-off fills the result queue; then a mid-query pause
  task automatic test_backpressure();
    wait_idle();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 60;
    repeat (6) send_text("Ab ");
    send_text("al be");
    // sender waits with a term byte still held back
    wait_idle();
    send_text("ta ga");
    send_end();
  endtask

  // random queries under four idling mixes, fresh limits per mix
  task automatic test_random_queries();
    int mix_idle [4] = '{0, 59, 0, 21};
    int mix_stall [4] = '{0, 0, 59, 21};
    int first;
    for (int m = 0; m < 4; m++) begin
      wait_idle();
      idle_pct  = mix_idle[m];
      stall_pct = mix_stall[m];
      set_limits(pick_limit(255), pick_limit(1023), pick_limit(255), pick_limit(255));
      first = beats_sent;
      while (beats_sent - first < 10) begin
        send_random_query();
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_MAX_TERM;
    cfg_data   = 10'd0;
    in_valid   = 1'b0;
    in_cmd     = CMD_BYTE;
    in_byte    = 8'd0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_left  = 0;
    fail_count = 0;
    beats_sent = 0;
    lim_term   = MAX_TERM_RST;
    lim_phrase = MAX_PHRASE_RST;
    lim_words  = MAX_WORDS_RST;
    lim_units  = MAX_UNITS_RST;
    clear_scan();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_basic_queries();
    test_limits();
    test_backpressure();
    test_random_queries();

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sqt_pkg.sv
hw/rtl/search_query_tokenizer_unit.sv
sim/tb_top.sv
